// ===== design/oaht_pkg.sv =====
`default_nettype none

package oaht_pkg;

  // default geometry
  localparam int TABLE_SIZE_DEF = 1024;
  localparam int KEY_BITS_DEF   = 32;

  // field widths of the stream beats
  localparam int REQ_W    = 2;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;
  localparam int STRIDE_W = 10;

  localparam int IN_DATA_W  = KEY_W + VALUE_W;
  localparam int OUT_RAW_W  = VALUE_W + COUNT_W + COUNT_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 10'd3;

  // request codes
  localparam logic [REQ_W-1:0] REQ_FIND   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  // slot tags
  localparam logic [1:0] TAG_FREE     = 2'd0;
  localparam logic [1:0] TAG_OCCUPIED = 2'd1;
  localparam logic [1:0] TAG_TOMB     = 2'd2;

  // request sequencer states
  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_PROBE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// ===== design/oaht_modred.sv =====
`default_nettype none

// remainder of an unsigned word by a fixed modulus, eight bits per cycle, msb first
module oaht_modred #(
  parameter int MODULUS = 1024,
  parameter int IN_W    = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [IN_W-1:0]             din,
  output logic                             busy,
  output logic [$clog2(MODULUS)-1:0]       result
);

  localparam int AW  = $clog2(MODULUS);
  localparam int RW  = AW + 1;
  localparam int NB  = (IN_W + 7) / 8;
  localparam int SW  = NB * 8;
  localparam int CNW = $clog2(NB + 1);

  logic [SW-1:0]  sh;
  logic [RW-1:0]  r;
  logic [RW-1:0]  racc;
  logic [CNW-1:0] cnt;

  // one byte of restoring reduction
  always_comb begin
    racc = r;
    for (int i = 0; i < 8; i++) begin
      racc = {racc[RW-2:0], sh[SW-1-i]};
      if (racc >= RW'(MODULUS)) begin
        racc = racc - RW'(MODULUS);
      end
    end
  end

  // byte counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNW'(NB);
    end else if (cnt != '0) begin
      cnt <= cnt - CNW'(1);
    end
  end

  // operand shifter and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      sh <= SW'(din);
      r  <= '0;
    end else if (cnt != '0) begin
      sh <= sh << 8;
      r  <= racc;
    end
  end

  assign busy   = (cnt != '0);
  assign result = r[AW-1:0];

endmodule

`default_nettype wire

// ===== design/open_addressing_hash_table.sv =====
// Open-addressing hash table with tombstones, one request at a time.
// Request beats come in on s_axis: tuser carries the request type (find,
// insert, delete), tdata the key and the value. Each request gives exactly
// one result beat on m_axis: tuser carries the status, tdata the found
// value, the occupied entry count after the request and the slots probed.
// cfg_we/cfg_wdata set the probe stride; write it only while idle.
// The home slot and the reduced stride each come from their own byte-serial
// remainder unit, and the sequencer waits in its hash state until both are
// done; then the first slot is read and the probe walks one slot per cycle
// through the synchronous tag and key/value memories. The result beat is
// loaded into the output register as the sequencer returns to idle. Requests
// rejected up front (full, empty, reserved type) skip the hash and probe
// states.
// After reset the tag memory is swept to free, one slot a cycle, over all
// TABLE_SIZE slots; s_axis_tready stays low during the sweep.
// The result sits in an output register: a new request is taken while it
// waits, but that request's result waits until the previous beat is taken.
`default_nettype none

module open_addressing_hash_table #(
  parameter int TABLE_SIZE = oaht_pkg::TABLE_SIZE_DEF,
  parameter int KEY_BITS   = oaht_pkg::KEY_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // config
  input  wire logic                              cfg_we,
  input  wire logic [oaht_pkg::STRIDE_W-1:0]     cfg_wdata,
  // request stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [oaht_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // key[31:0], value[63:32]
  input  wire logic [oaht_pkg::REQ_W-1:0]        s_axis_tuser,  // req_type[1:0]
  // result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [oaht_pkg::OUT_DATA_W-1:0]        m_axis_tdata,  // found_value[31:0],
                                                                // entry_count[42:32],
                                                                // probe_count[53:43]
  output logic [oaht_pkg::STATUS_W-1:0]          m_axis_tuser   // status[1:0]
);

  import oaht_pkg::*;

  localparam int AW = $clog2(TABLE_SIZE);
  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam int PW = $clog2(TABLE_SIZE + 2);

  state_t state;
  state_t state_next;

  // storage
  logic [1:0]          tag_mem [TABLE_SIZE];
  logic [KW+VALUE_W-1:0] kv_mem [TABLE_SIZE];
  logic [1:0]          tag_rd;
  logic [KW+VALUE_W-1:0] kv_rd;

  logic                tag_we;
  logic [AW-1:0]       tag_wa;
  logic [1:0]          tag_wd;
  logic                kv_we;

  // registers
  logic [STRIDE_W-1:0] stride;
  logic [AW-1:0]       clr_addr;
  logic [REQ_W-1:0]    req_q;
  logic [KW-1:0]       key_q;
  logic [VALUE_W-1:0]  val_q;
  logic [CW-1:0]       occ;
  logic [AW-1:0]       pos;
  logic [AW-1:0]       chk_pos;
  logic [AW-1:0]       tomb_pos;
  logic                have_tomb;
  logic                chk_vld;
  logic [PW-1:0]       nprobe;
  logic [STATUS_W-1:0] res_status;
  logic [VALUE_W-1:0]  res_fval;
  logic [PW-1:0]       res_probes;
  logic [STATUS_W-1:0] out_status;
  logic [VALUE_W-1:0]  out_fval;
  logic [COUNT_W-1:0]  out_entry;
  logic [COUNT_W-1:0]  out_probes;
  logic                out_vld;

  // remainder units
  logic                hash_start;
  logic                key_busy;
  logic                step_busy;
  logic [AW-1:0]       home;
  logic [AW-1:0]       step;

  // probe evaluation
  logic                s_acc;
  logic                out_free;
  logic [AW:0]         pos_sum;
  logic [AW-1:0]       pos_wrap;
  logic [PW-1:0]       n_new;
  logic                hit;
  logic                is_free;
  logic                is_last;
  logic                tomb_now;
  logic                usable;
  logic                stop;
  logic [AW-1:0]       slot;
  logic [CW+COUNT_W-1:0] occ_wide;
  logic [PW+COUNT_W-1:0] probes_wide;

  assign s_acc      = s_axis_tvalid && s_axis_tready;
  assign out_free   = !out_vld || m_axis_tready;
  assign hash_start = s_acc && (state_next == S_HASH);

  oaht_modred #(
    .MODULUS (TABLE_SIZE),
    .IN_W    (KW)
  ) u_key_mod (
    .clk    (clk),
    .rst    (rst),
    .start  (hash_start),
    .din    (s_axis_tdata[KW-1:0]),
    .busy   (key_busy),
    .result (home)
  );

  oaht_modred #(
    .MODULUS (TABLE_SIZE),
    .IN_W    (STRIDE_W)
  ) u_step_mod (
    .clk    (clk),
    .rst    (rst),
    .start  (hash_start),
    .din    (stride),
    .busy   (step_busy),
    .result (step)
  );

  // next probe address
  assign pos_sum  = {1'b0, pos} + {1'b0, step};
  assign pos_wrap = (pos_sum >= (AW+1)'(TABLE_SIZE)) ?
                    AW'(pos_sum - (AW+1)'(TABLE_SIZE)) : pos_sum[AW-1:0];

  // slot check on the data read last cycle
  always_comb begin
    n_new    = nprobe + PW'(1);
    hit      = (tag_rd == TAG_OCCUPIED) && (kv_rd[KW-1:0] == key_q);
    is_free  = (tag_rd == TAG_FREE);
    is_last  = (n_new == PW'(TABLE_SIZE));
    tomb_now = (tag_rd == TAG_TOMB) && !have_tomb;
    usable   = is_free || have_tomb || tomb_now;
    stop     = (state == S_PROBE) && chk_vld && (is_free || hit || is_last);
    if (hit) begin
      slot = chk_pos;
    end else if (have_tomb) begin
      slot = tomb_pos;
    end else begin
      slot = chk_pos;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == AW'(TABLE_SIZE - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_acc) begin
          priority if (s_axis_tuser == REQ_FIND) begin
            state_next = S_HASH;
          end else if (s_axis_tuser == REQ_INSERT) begin
            state_next = (occ >= CW'(TABLE_SIZE)) ? S_DONE : S_HASH;
          end else if (s_axis_tuser == REQ_DELETE) begin
            state_next = (occ == '0) ? S_DONE : S_HASH;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_HASH: begin
        if (!key_busy && !step_busy) state_next = S_PROBE;
      end
      S_PROBE: begin
        if (stop) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // stride register
  always_ff @(posedge clk) begin
    if (rst) begin
      stride <= STRIDE_RESET;
    end else if (cfg_we) begin
      stride <= cfg_wdata;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (s_acc) begin
      req_q <= s_axis_tuser;
      key_q <= s_axis_tdata[KW-1:0];
      val_q <= s_axis_tdata[KEY_W +: VALUE_W];
    end
  end

  // probe walk
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_vld   <= 1'b0;
      have_tomb <= 1'b0;
      nprobe    <= '0;
    end else if (state == S_HASH) begin
      pos       <= home;
      chk_vld   <= 1'b0;
      have_tomb <= 1'b0;
      nprobe    <= '0;
    end else if (state == S_PROBE) begin
      pos     <= pos_wrap;
      chk_pos <= pos;
      chk_vld <= 1'b1;
      if (chk_vld) begin
        nprobe <= n_new;
        if (tomb_now) begin
          have_tomb <= 1'b1;
          tomb_pos  <= chk_pos;
        end
      end
    end
  end

  // result and table update
  always_comb begin
    tag_we = 1'b0;
    tag_wa = clr_addr;
    tag_wd = TAG_FREE;
    kv_we  = 1'b0;
    if (state == S_CLEAR) begin
      tag_we = 1'b1;
    end else if (stop) begin
      tag_wa = slot;
      if (req_q == REQ_INSERT && !hit && usable) begin
        tag_we = 1'b1;
        tag_wd = TAG_OCCUPIED;
        kv_we  = 1'b1;
      end else if (req_q == REQ_DELETE && hit) begin
        tag_we = 1'b1;
        tag_wd = TAG_TOMB;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (stop && kv_we) begin
      occ <= occ + CW'(1);
    end else if (stop && tag_we) begin
      occ <= occ - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_acc) begin
      res_fval   <= '0;
      res_probes <= '0;
      priority if (s_axis_tuser == REQ_INSERT) begin
        res_status <= ST_FULL;
      end else if (s_axis_tuser == REQ_DELETE) begin
        res_status <= ST_EMPTY;
      end else begin
        res_status <= ST_MISS;
      end
    end else if (stop) begin
      res_fval   <= '0;
      res_probes <= n_new;
      res_status <= ST_MISS;
      unique case (req_q)
        REQ_FIND: begin
          if (hit) begin
            res_status <= ST_OK;
            res_fval   <= kv_rd[KW +: VALUE_W];
          end
        end
        REQ_INSERT: begin
          if (!hit && !usable) begin
            res_status <= ST_FULL;
          end else if (!hit) begin
            res_status <= ST_OK;
            res_probes <= n_new + PW'(1);
          end
        end
        REQ_DELETE: begin
          if (hit) begin
            res_status <= ST_OK;
            res_probes <= n_new + PW'(1);
          end
        end
        default: res_status <= ST_MISS;
      endcase
    end
  end

  // tag memory
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PROBE) begin
      tag_rd <= tag_mem[pos];
    end
  end

  // key and value memory
  always_ff @(posedge clk) begin
    if (kv_we) begin
      kv_mem[slot] <= {val_q, key_q};
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PROBE) begin
      kv_rd <= kv_mem[pos];
    end
  end

  // output register
  assign occ_wide    = {{COUNT_W{1'b0}}, occ};
  assign probes_wide = {{COUNT_W{1'b0}}, res_probes};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_vld <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_status <= res_status;
      out_fval   <= res_fval;
      out_entry  <= occ_wide[COUNT_W-1:0];
      out_probes <= probes_wide[COUNT_W-1:0];
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_vld;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = OUT_DATA_W'({out_probes, out_entry, out_fval});

endmodule

`default_nettype wire
